// ===== design/b64e_pkg.sv =====
// shared types, constants and character mapping for the base64 encoder
`default_nettype none
package b64e_pkg;

  localparam logic [7:0] CHAR_PAD   = 8'h3D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_D0    = 8'h30;

  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_THIRD  = 2'd2;
  localparam logic [1:0] POS_UNUSED = 2'd3;

  localparam logic [1:0] CH_IDX_LAST = 2'd3;

  // one closed group on its way from front to back
  typedef struct packed {
    logic [23:0] triple;
    logic [1:0]  nbm1;   // real bytes minus one
    logic        last;
  } grp_t;

  typedef struct packed {
    logic       emit;
    logic [1:0] idx;
    logic       pad;
  } back_stat_t;

  function automatic logic [7:0] b64_char(input logic [5:0] idx);
    logic [7:0] ch;
    if (idx < 6'd26) begin
      ch = CHAR_UA + {2'b00, idx};
    end else if (idx < 6'd52) begin
      ch = CHAR_LA + {2'b00, idx} - 8'd26;
    end else if (idx < 6'd62) begin
      ch = CHAR_D0 + {2'b00, idx} - 8'd52;
    end else if (idx == 6'd62) begin
      ch = CHAR_PLUS;
    end else begin
      ch = CHAR_SLASH;
    end
    return ch;
  endfunction

endpackage
`default_nettype wire

// ===== design/b64e_front.sv =====
// front part: gathers bytes into groups and closes a group on its third or last byte
`default_nettype none
module b64e_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    in_byte,
  input  wire logic          in_last_byte,
  input  wire logic          q_full,
  output logic               q_push,
  output b64e_pkg::grp_t     q_wdata
);

  logic [15:0] pend_r, pend_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic [1:0]  pos_eff;
  logic        accept;
  logic        close;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign pos_eff  = (pos_r == b64e_pkg::POS_UNUSED) ? b64e_pkg::POS_FIRST : pos_r;
  assign close    = in_last_byte || (pos_eff == b64e_pkg::POS_THIRD);
  assign q_push   = accept && close;

  always_comb begin
    q_wdata.nbm1 = pos_eff;
    q_wdata.last = in_last_byte;
    unique case (pos_eff)
      b64e_pkg::POS_FIRST:  q_wdata.triple = {in_byte, 16'h0000};
      b64e_pkg::POS_SECOND: q_wdata.triple = {pend_r[15:8], in_byte, 8'h00};
      default:              q_wdata.triple = {pend_r, in_byte};
    endcase
  end

  always_comb begin
    pend_nxt = pend_r;
    pos_nxt  = pos_r;
    if (accept) begin
      if (close) begin
        pend_nxt = 16'h0000;
        pos_nxt  = b64e_pkg::POS_FIRST;
      end else begin
        pend_nxt = (pos_eff == b64e_pkg::POS_FIRST) ? {in_byte, 8'h00}
                                                    : {pend_r[15:8], in_byte};
        pos_nxt  = pos_eff + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 16'h0000;
      pos_r  <= b64e_pkg::POS_FIRST;
    end else begin
      pend_r <= pend_nxt;
      pos_r  <= pos_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/b64e_queue.sv =====
// two-entry group queue between front and back
`default_nettype none
module b64e_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire b64e_pkg::grp_t  wdata,
  input  wire logic            pop,
  output b64e_pkg::grp_t       rdata,
  output logic                 full,
  output logic                 empty
);

  b64e_pkg::grp_t ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/b64e_back.sv =====
// back part: turns one group into four characters, one per cycle while out_stall is low, into an output register
`default_nettype none
module b64e_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire b64e_pkg::grp_t  q_rdata,
  input  wire logic            q_empty,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [7:0]           out_char,
  output logic                 out_last_char,
  output b64e_pkg::back_stat_t stat
);

  b64e_pkg::grp_t cur_r, cur_nxt;
  logic       busy_r, busy_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       ov_r, ov_nxt;
  logic [7:0] ch_r, ch_nxt;
  logic       lc_r, lc_nxt;
  logic       adv, emit, load;
  logic [5:0] sext;
  logic       is_pad;

  assign adv   = !ov_r || !out_stall;
  assign emit  = busy_r && adv;
  assign load  = !busy_r || (emit && idx_r == b64e_pkg::CH_IDX_LAST);
  assign q_pop = load && !q_empty;

  always_comb begin
    case (idx_r)
      2'd0:    sext = cur_r.triple[23:18];
      2'd1:    sext = cur_r.triple[17:12];
      2'd2:    sext = cur_r.triple[11:6];
      default: sext = cur_r.triple[5:0];
    endcase
  end

  // characters past the real data are padding
  assign is_pad = idx_r > (cur_r.nbm1 + 2'd1);

  always_comb begin
    cur_nxt  = cur_r;
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    ov_nxt   = ov_r;
    ch_nxt   = ch_r;
    lc_nxt   = lc_r;
    if (adv) begin
      ov_nxt = busy_r;
    end
    if (emit) begin
      ch_nxt  = is_pad ? b64e_pkg::CHAR_PAD : b64e_pkg::b64_char(sext);
      lc_nxt  = cur_r.last && (idx_r == b64e_pkg::CH_IDX_LAST);
      idx_nxt = idx_r + 2'd1;
    end
    if (load) begin
      busy_nxt = !q_empty;
    end
    if (q_pop) begin
      cur_nxt = q_rdata;
      idx_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    ch_r  <= ch_nxt;
    lc_r  <= lc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      ov_r   <= ov_nxt;
    end
  end

  assign out_valid     = ov_r;
  assign out_char      = ch_r;
  assign out_last_char = lc_r;
  assign stat.emit     = emit;
  assign stat.idx      = idx_r;
  assign stat.pad      = is_pad;

endmodule
`default_nettype wire

// ===== design/base64_encoder_unit.sv =====
// Streaming base64 encoder: bytes in, ASCII characters out (RFC 4648 alphabet).
// A group's closing byte goes into the queue, then into the back end's group register,
// and its first character into the output register. The back end sends one character
// per cycle while out_stall is low, four per group; the front takes a byte per cycle
// unless the two-entry group queue stalls the input when the back end falls behind.
// Reset (synchronous, rst_n low) clears the pending bytes, group position and queue.
`default_nettype none
module base64_encoder_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_char,
  output logic            out_last_char
);

  b64e_pkg::grp_t       q_wdata;
  b64e_pkg::grp_t       q_rdata;
  b64e_pkg::back_stat_t bk_stat;
  logic                 q_push, q_pop, q_full, q_empty;

  b64e_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .in_last_byte (in_last_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  b64e_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  b64e_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_rdata       (q_rdata),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char      (out_char),
    .out_last_char (out_last_char),
    .stat          (bk_stat)
  );

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("group pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("group popped from empty queue");

  a_pad_late: assert property (@(posedge clk) disable iff (!rst_n)
    (bk_stat.emit && bk_stat.pad) |-> (bk_stat.idx == 2'd2 || bk_stat.idx == 2'd3))
    else $error("padding in first two characters of a group");

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.emit |=> out_valid) else $error("emitted character not shown");
`endif

endmodule
`default_nettype wire
